>>> rtl/gwra_pkg.sv
// ----------------------------------------------------------------------------
// gwra_pkg
// Shared types and constants for the gated window range averager.
// ----------------------------------------------------------------------------
package gwra_pkg;

  // Build-time sizes
  localparam int CAPTURE_DEPTH = 128;
  localparam int SAMPLE_BITS   = 16;

  // Field widths
  localparam int DIST_W  = 16;
  localparam int SUM_W   = 24;
  localparam int CNT_W   = 8;
  localparam int LEN_W   = 8;
  localparam int CAPL_W  = 8;
  localparam int SLOT_W  = 7;
  localparam int MEAN_W  = 24;
  localparam int FRAC_W  = 8;
  localparam int DIVD_W  = SUM_W + FRAC_W;
  localparam int STEP_W  = $clog2(DIVD_W);

  localparam logic [DIST_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= DIST_W) ? {DIST_W{1'b1}} : DIST_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [10:0] CAPTURE_DEPTH_W = 11'(CAPTURE_DEPTH);

  // Register reset values
  localparam logic [DIST_W-1:0] VALID_LIMIT_RST   = 16'd1000;
  localparam logic [LEN_W-1:0]  WINDOW_LENGTH_RST = 8'd20;
  localparam logic [CAPL_W-1:0] CAPTURE_LIMIT_RST = 8'd30;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_VALID_LIMIT   = 2'd0;
  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [1:0] REG_CAPTURE_LIMIT = 2'd2;

  // Job queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One closed window, handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  valid_count;
    logic [CNT_W-1:0]  skip_count;
    logic [SLOT_W-1:0] slot;
    logic              take;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

>>> rtl/gated_window_range_averager.sv
// ----------------------------------------------------------------------------
// gated_window_range_averager
// Gated block average of range samples with capture-slot bookkeeping.
// ----------------------------------------------------------------------------
// Flow: a sample that closes a window is written to the queue at its accepting
//   edge; the back end then pops and loads the job and runs 32 divide steps
//   before the result is valid; an empty window skips the divide.
// Throughput: one sample per cycle while the queue has room; the back
//   end takes one job at a time and no new one until its result is taken.
// Reset: synchronous, active high; clears the window, the capture index,
//   the queue and the divider, and loads the register defaults.
// ----------------------------------------------------------------------------
module gated_window_range_averager (
  input  logic        clk,
  input  logic        rst,
  // Sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] distance_mm
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [23:0] mean_q8, [31:24] valid_in_window,
                                 // [39:32] skipped_in_window, [46:40] capture_slot
  output logic [1:0]  m_tuser,   // [0] no_valid, [1] captured
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gwra_pkg::*;

  logic [DIST_W-1:0] valid_limit;
  logic [LEN_W-1:0]  window_length;
  logic [CAPL_W-1:0] capture_limit;
  logic              cfg_wr;
  logic [1:0]        reg_index;

  logic              push;
  job_t              push_job;
  logic              pop;
  job_t              pop_job;
  queue_status_t     q_status;

  // Register file: index is the word address, writes past the list are dropped
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_wr    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_limit   <= VALID_LIMIT_RST;
      window_length <= WINDOW_LENGTH_RST;
      capture_limit <= CAPTURE_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_index)
        REG_VALID_LIMIT:   valid_limit   <= pwdata[DIST_W-1:0];
        REG_WINDOW_LENGTH: window_length <= pwdata[LEN_W-1:0];
        REG_CAPTURE_LIMIT: capture_limit <= pwdata[CAPL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_VALID_LIMIT:   prdata = {16'd0, valid_limit};
      REG_WINDOW_LENGTH: prdata = {24'd0, window_length};
      REG_CAPTURE_LIMIT: prdata = {24'd0, capture_limit};
      default:           prdata = '0;
    endcase
  end

  // Front end: gating, accumulation, window close and capture index
  gwra_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .valid_limit   (valid_limit),
    .window_length (window_length),
    .capture_limit (capture_limit),
    .q_status      (q_status),
    .push          (push),
    .push_job      (push_job)
  );

  // Closed windows wait here while the divider is busy
  gwra_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  // Back end: mean by serial division, then the output transaction
  gwra_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop_job  (pop_job),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> rtl/gwra_front.sv
// ----------------------------------------------------------------------------
// gwra_front
// Accepts samples, gates them against the limit, accumulates the window and
// queues one job per closed window together with its capture slot.
// ----------------------------------------------------------------------------
module gwra_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [gwra_pkg::DIST_W-1:0]   s_tdata,
  input  logic [gwra_pkg::DIST_W-1:0]   valid_limit,
  input  logic [gwra_pkg::LEN_W-1:0]    window_length,
  input  logic [gwra_pkg::CAPL_W-1:0]   capture_limit,
  input  gwra_pkg::queue_status_t       q_status,
  output logic                          push,
  output gwra_pkg::job_t                push_job
);
  import gwra_pkg::*;

  logic [SUM_W-1:0]  window_sum;
  logic [CNT_W-1:0]  valid_count;
  logic [CNT_W-1:0]  skip_count;
  logic [CAPL_W-1:0] capture_index;

  logic [DIST_W-1:0] sample;
  logic              is_valid;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  valid_next;
  logic [CNT_W-1:0]  skip_next;
  logic [CNT_W:0]    total;
  logic              close;
  logic              take;
  logic              accept;

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;

  assign sample   = s_tdata & SAMPLE_MASK;
  assign is_valid = sample < valid_limit;
  assign sum_ext  = {1'b0, window_sum} + (SUM_W+1)'(sample);

  always_comb begin
    sum_next   = window_sum;
    valid_next = valid_count;
    skip_next  = skip_count;
    if (is_valid) begin
      sum_next = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      if (valid_count != {CNT_W{1'b1}}) valid_next = valid_count + CNT_W'(1);
    end else begin
      if (skip_count != {CNT_W{1'b1}}) skip_next = skip_count + CNT_W'(1);
    end
  end

  assign total = (CNT_W+1)'(valid_next) + (CNT_W+1)'(skip_next);
  assign close = total >= (CNT_W+1)'(window_length);
  assign take  = (capture_index < capture_limit) &&
                 (11'(capture_index) < CAPTURE_DEPTH_W);

  assign push                 = accept && close;
  assign push_job.sum         = sum_next;
  assign push_job.valid_count = valid_next;
  assign push_job.skip_count  = skip_next;
  assign push_job.slot        = take ? capture_index[SLOT_W-1:0] : '0;
  assign push_job.take        = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum    <= '0;
      valid_count   <= '0;
      skip_count    <= '0;
      capture_index <= '0;
    end else if (accept) begin
      if (close) begin
        window_sum  <= '0;
        valid_count <= '0;
        skip_count  <= '0;
        if (take) capture_index <= capture_index + CAPL_W'(1);
      end else begin
        window_sum  <= sum_next;
        valid_count <= valid_next;
        skip_count  <= skip_next;
      end
    end
  end

endmodule

>>> rtl/gwra_queue.sv
// ----------------------------------------------------------------------------
// gwra_queue
// Short job queue that lets the front and the divider stall independently.
// ----------------------------------------------------------------------------
module gwra_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  gwra_pkg::job_t          push_job,
  input  logic                    pop,
  output gwra_pkg::job_t          pop_job,
  output gwra_pkg::queue_status_t status
);
  import gwra_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_job      = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop)      count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

endmodule

>>> rtl/gwra_back.sv
// ----------------------------------------------------------------------------
// gwra_back
// Takes one job at a time, divides sum*256 by the valid count one quotient
// bit per cycle and holds the result in the output register.
// ----------------------------------------------------------------------------
module gwra_back (
  input  logic                    clk,
  input  logic                    rst,
  input  gwra_pkg::queue_status_t q_status,
  input  gwra_pkg::job_t          pop_job,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [47:0]             m_tdata,
  output logic [1:0]              m_tuser
);
  import gwra_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic              load;
  logic              finish;

  job_t              job;
  logic [CNT_W-1:0]  rem;
  logic [DIVD_W-1:0] dq;
  logic [STEP_W-1:0] step;
  logic [MEAN_W-1:0] mean_q8;

  logic [CNT_W:0]    trial;
  logic              qbit;
  logic [CNT_W:0]    trial_sub;
  logic [DIVD_W-1:0] dq_next;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    finish     = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_status.empty) begin
          pop  = 1'b1;
          load = 1'b1;
          state_next = (pop_job.valid_count == '0) ? B_OUT : B_DIV;
        end
      end
      B_DIV: begin
        if (step == STEP_W'(DIVD_W - 1)) begin
          finish     = 1'b1;
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (m_tready) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Restoring division step: remainder stays below the 8-bit divisor
  assign trial     = {rem, dq[DIVD_W-1]};
  assign qbit      = trial >= {1'b0, job.valid_count};
  assign trial_sub = trial - {1'b0, job.valid_count};
  assign dq_next   = {dq[DIVD_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (load) begin
      job     <= pop_job;
      rem     <= '0;
      dq      <= {pop_job.sum, {FRAC_W{1'b0}}};
      step    <= '0;
      mean_q8 <= '0;
    end else if (state == B_DIV) begin
      rem  <= qbit ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      dq   <= dq_next;
      step <= step + STEP_W'(1);
      if (finish) begin
        mean_q8 <= (dq_next[DIVD_W-1:MEAN_W] != '0) ? {MEAN_W{1'b1}}
                                                    : dq_next[MEAN_W-1:0];
      end
    end
  end

  assign m_tvalid = state == B_OUT;
  assign m_tdata  = {1'b0, job.slot, job.skip_count, job.valid_count, mean_q8};
  assign m_tuser  = {job.take, job.valid_count == '0};

endmodule
